// ===== rtl/ipcpwm_pkg.sv =====
// Package for the inverse Park / Clarke PWM duty pipeline.
// Holds the fixed-point constants and widths; depends on nothing.
package ipcpwm_pkg;

  // Quarter-wave sine polynomial coefficients (Q16)
  localparam logic [16:0] QW_A = 17'd102944;
  localparam logic [15:0] QW_B = 16'd42048;
  localparam logic [15:0] QW_C = 16'd4640;

  // sqrt(3) in Q16 is 65536 + SQ3_FRAC
  localparam logic [16:0] SQ3_FRAC = 17'd47976;

  // Percent full scale
  localparam logic [6:0] DUTY_FULL = 7'd100;

  // Widths of the phase and divider datapaths
  localparam int unsigned PH_W  = 53;
  localparam int unsigned REM_W = 58;
  localparam int unsigned DIV_STEPS = 7;

endpackage

// ===== rtl/inverse_park_clarke_pwm_duty_top.sv =====
// Inverse Park / inverse Clarke PWM duty pipeline, top level.
// Depends on ipcpwm_pkg for constants.
//
// Usage:
//   Input stream (in_*): one request per command, tdata holds q_voltage,
//   d_voltage and electrical_angle. Result stream (out_*): one request per
//   command with the three phase duties in percent.
//   Configuration (cfg_*): writes supply_voltage (Q8.8 volts); always ready.
//   Write it only while the pipeline is empty.
//   Throughput: one command per clock while no result waits on out_tready. From the
//   input handshake to out_tvalid a command passes 18 register stages: sine polynomial (5),
//   rotation and sqrt(3) scaling (5), clamp and scale by 100 (1), then a
//   7-step restoring divide by the supply (7).
//   Reset (rst_n low, synchronous) empties the pipeline and sets the supply
//   to 12.0 V. While a result waits with out_tready low the whole pipeline
//   holds and in_tready drops; nothing is lost or repeated.
//   SINE_TABLE_SIZE must be a power of two from 64 to 65536.
module inverse_park_clarke_pwm_duty_top import ipcpwm_pkg::*; #(
  parameter int unsigned SINE_TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // q_voltage[15:0], d_voltage[31:16], electrical_angle[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // duty_a[6:0], duty_b[13:7], duty_c[20:14], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned NSTG = 18;
  localparam logic [15:0] PHASE_MASK = 16'(~(65536 / SINE_TABLE_SIZE - 1));

  logic [15:0]     supply_r;
  logic [NSTG-1:0] vld_r;
  logic            adv;

  assign adv       = !vld_r[NSTG-1] || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;
  assign out_tvalid = vld_r[NSTG-1];

  // Supply register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= 16'd3072;
    end else if (cfg_valid) begin
      supply_r <= cfg_data;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // ---------------- stage 1: quantize angle, fold to quarter wave
  logic signed [15:0] s1_q_r, s1_d_r;
  logic [16:0]        s1_w_r [2];
  logic               s1_neg_r [2];
  logic [16:0]        s1_w_nxt [2];
  logic               s1_neg_nxt [2];

  always_comb begin
    logic [15:0] p;
    logic [15:0] pk;
    logic [16:0] z;
    p = in_tdata[47:32] & PHASE_MASK;
    for (int k = 0; k < 2; k++) begin
      pk = (k == 0) ? p : p + 16'd16384;
      z  = {1'b0, pk[13:0], 2'b00};
      s1_w_nxt[k]   = pk[14] ? 17'd65536 - z : z;
      s1_neg_nxt[k] = pk[15];
    end
  end

  // ---------------- stages 2..5: quarter-wave polynomial
  logic signed [15:0] s2_q_r, s2_d_r, s3_q_r, s3_d_r, s4_q_r, s4_d_r, s5_q_r, s5_d_r;
  logic [16:0] s2_w_r [2], s3_w_r [2], s4_w_r [2];
  logic        s2_neg_r [2], s3_neg_r [2], s4_neg_r [2];
  logic [16:0] s2_w2_r [2], s3_w2_r [2];
  logic [15:0] s3_inner_r [2];
  logic [16:0] s4_mid_r [2];
  logic signed [17:0] s5_sc_r [2];   // 0: sine, 1: cosine
  logic [16:0] s2_w2_nxt [2];
  logic [15:0] s3_inner_nxt [2];
  logic [16:0] s4_mid_nxt [2];
  logic signed [17:0] s5_sc_nxt [2];

  always_comb begin
    logic [33:0] t2, t3, t4, t5;
    for (int k = 0; k < 2; k++) begin
      t2 = 34'(s1_w_r[k]) * 34'(s1_w_r[k]);
      s2_w2_nxt[k] = t2[32:16];
      t3 = 34'(s2_w2_r[k]) * 34'(QW_C);
      s3_inner_nxt[k] = QW_B - t3[31:16];
      t4 = 34'(s3_w2_r[k]) * 34'(s3_inner_r[k]);
      s4_mid_nxt[k] = QW_A - t4[32:16];
      t5 = 34'(s4_w_r[k]) * 34'(s4_mid_r[k]);
      s5_sc_nxt[k] = s4_neg_r[k] ? -$signed({1'b0, t5[32:16]})
                                 : $signed({1'b0, t5[32:16]});
    end
  end

  // ---------------- stages 6..10: rotation, sqrt(3), phase sums
  logic signed [33:0] s6_dc_r, s6_qs_r, s6_ds_r, s6_qc_r;
  logic signed [34:0] s7_alpha_r, s7_beta_r, s8_alpha_r, s8_beta_r;
  logic [32:0]        s8_bl_r;
  logic signed [34:0] s8_bh_r;
  logic signed [PH_W-1:0] s9_a40_r, s9_b40_r;
  logic signed [PH_W-1:0] s10_x_r [3];
  logic signed [PH_W-1:0] s9_b40_nxt, v40;
  logic signed [PH_W-1:0] s10_x_nxt [3];

  assign v40 = $signed({5'd0, supply_r, 32'd0});

  always_comb begin
    s9_b40_nxt = ($signed(PH_W'(s8_beta_r)) <<< 16)
               + ($signed(PH_W'(s8_bh_r)) <<< 17)
               + $signed({20'd0, s8_bl_r});
    s10_x_nxt[0] = (s9_a40_r <<< 1) + v40;
    s10_x_nxt[1] = s9_b40_r - s9_a40_r + v40;
    s10_x_nxt[2] = -s9_a40_r - s9_b40_r + v40;
  end

  // ---------------- stage 11 and divider: clamp, scale, restoring divide
  logic [REM_W-1:0] dv_rem_r [DIV_STEPS][3];
  logic [6:0]       dv_q_r [DIV_STEPS][3];
  logic             dv_zero_r [DIV_STEPS][3];
  logic             dv_full_r [DIV_STEPS][3];
  logic [REM_W-1:0] dv_rem_nxt [DIV_STEPS][3];
  logic [6:0]       dv_q_nxt [DIV_STEPS][3];
  logic [REM_W-1:0] y0_nxt [3];
  logic             zero0_nxt [3], full0_nxt [3];
  logic [6:0]       duty_nxt [3];
  logic [6:0]       duty_r [3];
  logic signed [PH_W-1:0] lim2v;

  assign lim2v = $signed({4'd0, supply_r, 33'd0});

  always_comb begin
    logic [REM_W-1:0] dsh;
    for (int k = 0; k < 3; k++) begin
      zero0_nxt[k] = (s10_x_r[k] <= 0) || (supply_r == 16'd0);
      full0_nxt[k] = s10_x_r[k] >= lim2v;
      y0_nxt[k]    = REM_W'(s10_x_r[k][48:0]) * REM_W'(DUTY_FULL);
      // one quotient bit per stage, most significant first
      for (int j = 0; j < DIV_STEPS; j++) begin
        dsh = REM_W'(supply_r) << (33 + DIV_STEPS - 1 - j);
        dv_rem_nxt[j][k] = dv_rem_r[j][k];
        dv_q_nxt[j][k]   = dv_q_r[j][k];
        if (dv_rem_r[j][k] >= dsh) begin
          dv_rem_nxt[j][k] = dv_rem_r[j][k] - dsh;
          dv_q_nxt[j][k][DIV_STEPS-1-j] = 1'b1;
        end
      end
      priority if (dv_zero_r[DIV_STEPS-1][k]) begin
        duty_nxt[k] = 7'd0;
      end else if (dv_full_r[DIV_STEPS-1][k]) begin
        duty_nxt[k] = DUTY_FULL;
      end else begin
        duty_nxt[k] = dv_q_nxt[DIV_STEPS-1][k];
      end
    end
  end

  // ---------------- datapath registers, all held on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_q_r <= in_tdata[15:0];
      s1_d_r <= in_tdata[31:16];
      s2_q_r <= s1_q_r;  s2_d_r <= s1_d_r;
      s3_q_r <= s2_q_r;  s3_d_r <= s2_d_r;
      s4_q_r <= s3_q_r;  s4_d_r <= s3_d_r;
      s5_q_r <= s4_q_r;  s5_d_r <= s4_d_r;
      for (int k = 0; k < 2; k++) begin
        s1_w_r[k]     <= s1_w_nxt[k];
        s1_neg_r[k]   <= s1_neg_nxt[k];
        s2_w_r[k]     <= s1_w_r[k];
        s2_neg_r[k]   <= s1_neg_r[k];
        s2_w2_r[k]    <= s2_w2_nxt[k];
        s3_w_r[k]     <= s2_w_r[k];
        s3_neg_r[k]   <= s2_neg_r[k];
        s3_w2_r[k]    <= s2_w2_r[k];
        s3_inner_r[k] <= s3_inner_nxt[k];
        s4_w_r[k]     <= s3_w_r[k];
        s4_neg_r[k]   <= s3_neg_r[k];
        s4_mid_r[k]   <= s4_mid_nxt[k];
        s5_sc_r[k]    <= s5_sc_nxt[k];
      end
      // rotation products
      s6_dc_r <= s5_d_r * s5_sc_r[1];
      s6_qs_r <= s5_q_r * s5_sc_r[0];
      s6_ds_r <= s5_d_r * s5_sc_r[0];
      s6_qc_r <= s5_q_r * s5_sc_r[1];
      s7_alpha_r <= 35'(s6_dc_r) - 35'(s6_qs_r);
      s7_beta_r  <= 35'(s6_ds_r) + 35'(s6_qc_r);
      // beta * sqrt(3) fraction split into two partial products
      s8_alpha_r <= s7_alpha_r;
      s8_beta_r  <= s7_beta_r;
      s8_bl_r    <= 33'(s7_beta_r[16:0]) * 33'(SQ3_FRAC);
      s8_bh_r    <= $signed(s7_beta_r[34:17]) * $signed({1'b0, SQ3_FRAC});
      s9_a40_r   <= $signed(PH_W'(s8_alpha_r)) <<< 16;
      s9_b40_r   <= s9_b40_nxt;
      for (int k = 0; k < 3; k++) begin
        s10_x_r[k]      <= s10_x_nxt[k];
        dv_rem_r[0][k]  <= y0_nxt[k];
        dv_q_r[0][k]    <= 7'd0;
        dv_zero_r[0][k] <= zero0_nxt[k];
        dv_full_r[0][k] <= full0_nxt[k];
        for (int j = 1; j < DIV_STEPS; j++) begin
          dv_rem_r[j][k]  <= dv_rem_nxt[j-1][k];
          dv_q_r[j][k]    <= dv_q_nxt[j-1][k];
          dv_zero_r[j][k] <= dv_zero_r[j-1][k];
          dv_full_r[j][k] <= dv_full_r[j-1][k];
        end
        duty_r[k] <= duty_nxt[k];
      end
    end
  end

  assign out_tdata = {3'd0, duty_r[2], duty_r[1], duty_r[0]};

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the inverse Park / Clarke PWM duty pipeline.
// Predicts duties in 64/128-bit arithmetic; depends on ipcpwm_pkg and the top.
`timescale 1ns / 1ps

module tb_top import ipcpwm_pkg::*; ();

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned LAT = 18;

  typedef struct packed {
    logic [6:0] a;
    logic [6:0] b;
    logic [6:0] c;
  } duty_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  logic [15:0] supply_v;
  duty_t       duty_q[$];
  int          err_cnt;
  bit          idle_on;
  bit          hold_on;
  int          hold_cycles;

  inverse_park_clarke_pwm_duty_top #(.SINE_TABLE_SIZE(TABLE_SIZE)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Quarter-wave polynomial and signed sine, Q16
  function automatic longint qwave(longint w);
    longint w2, inner, mid;
    w2 = (w * w) >>> 16;
    inner = longint'(QW_B) - ((w2 * longint'(QW_C)) >>> 16);
    mid = longint'(QW_A) - ((w2 * inner) >>> 16);
    return (w * mid) >>> 16;
  endfunction

  function automatic longint sine16(logic [15:0] p);
    longint z, w, f;
    z = longint'(p[13:0]) << 2;
    w = p[14] ? 65536 - z : z;
    f = qwave(w);
    return p[15] ? -f : f;
  endfunction

  function automatic logic [6:0] phase_duty(logic signed [127:0] v,
                                            logic signed [127:0] full);
    if (v <= 0) return 7'd0;
    if (v >= full) return DUTY_FULL;
    return 7'((v * 100) / full);
  endfunction

  function automatic duty_t duty_of_cmd(logic [47:0] cmd);
    longint q, d, s, c, alpha, beta;
    logic [15:0] p;
    logic signed [127:0] a40, b40, v40, full;
    duty_t r;
    q = longint'($signed(cmd[15:0]));
    d = longint'($signed(cmd[31:16]));
    p = 16'((longint'(cmd[47:32]) * TABLE_SIZE >> 16) * (65536 / TABLE_SIZE));
    s = sine16(p);
    c = sine16(p + 16'd16384);
    alpha = d * c - q * s;
    beta = d * s + q * c;
    a40 = 128'(alpha) * 65536;
    b40 = 128'(beta) * (65536 + longint'(SQ3_FRAC));
    v40 = 128'(supply_v) << 32;
    full = v40 * 2;
    if (supply_v == 0) return '0;
    r.a = phase_duty(2 * a40 + v40, full);
    r.b = phase_duty(b40 - a40 + v40, full);
    r.c = phase_duty(-a40 - b40 + v40, full);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // Send one command request; prediction is queued at acceptance
  task automatic send_cmd(logic [15:0] q, logic [15:0] d, logic [15:0] ang);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ang, d, q};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    duty_q.push_back(duty_of_cmd({ang, d, q}));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (duty_q.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  task automatic write_supply(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    supply_v = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_volt();
    unique case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 2048) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] angs[8] = '{16'h0000, 16'hffff, 16'h4000, 16'h8000, 16'hc000,
                             16'h003f, 16'h0040, 16'h2aaa};
    send_cmd(16'h0000, 16'h0000, 16'h0000);
    foreach (angs[i]) send_cmd(16'h7fff, 16'h8000, angs[i]);
    foreach (angs[i]) send_cmd(16'h8000, 16'h7fff, angs[i]);
    send_cmd(16'h0100, 16'h0000, 16'h1234);
    send_cmd(16'hff00, 16'h0080, 16'h9abc);
    send_cmd(16'hffff, 16'hffff, 16'h5555);
    drain();
  endtask

  task automatic test_supply_range();
    logic [15:0] sups[5] = '{16'd0, 16'd256, 16'hffff, 16'h0001, 16'd1000};
    foreach (sups[i]) begin
      write_supply(sups[i]);
      repeat (12) send_cmd(rand_volt(), rand_volt(), 16'($urandom));
      drain();
    end
    write_supply(16'd3072);
  endtask

  // Long receiver stall while commands keep coming
  task automatic test_backpressure();
    hold_cycles = 60;
    hold_on = 1'b1;
    repeat (40) send_cmd(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
  endtask

  task automatic test_random();
    for (int k = 0; k < 1030; k++) begin
      if (k % 275 == 0) begin
        drain();
        write_supply(16'($urandom_range(256, 65535)));
      end
      if (k == 900) idle_on = 1'b0;
      send_cmd(rand_volt(), rand_volt(), 16'($urandom));
    end
    drain();
  endtask

  // Receiver: random stalls, long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_on) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_on = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    duty_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = duty_t'({out_tdata[6:0], out_tdata[13:7], out_tdata[20:14]});
      if (duty_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = duty_q.pop_front();
        if (got.a !== want.a) report_mismatch("duty_a", got.a, want.a);
        if (got.b !== want.b) report_mismatch("duty_b", got.b, want.b);
        if (got.c !== want.c) report_mismatch("duty_c", got.c, want.c);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    err_cnt = 0;
    idle_on = 1'b1;
    hold_on = 1'b0;
    hold_cycles = 0;
    supply_v = 16'd3072;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_supply_range();
    test_backpressure();
    test_random();
    if (err_cnt == 0 && duty_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ipcpwm_pkg.sv
rtl/inverse_park_clarke_pwm_duty_top.sv
bench/tb_top.sv
